### rtl/core/lav_pkg.sv
package lav_pkg;

    localparam int COORD_W = 32;
    localparam int MAG_BITS = 31;
    localparam int ROW_W = 2;
    localparam logic [ROW_W-1:0] ROW_LAST = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

endpackage

### rtl/core/look_at_view_matrix.sv
// look-at view matrix generator, signed fixed point with FRAC_BITS fraction bits
// input channel s_*: one beat carries eye, target and up vectors (nine 32-bit words)
// result channel m_*: four beats per input, matrix rows 0 to 3 in order; tlast marks
// row 3 and tuser carries the degenerate flag (zero-length vector met)
// the item runs through a long pipeline: difference, normalise z, cross, normalise x,
// cross, normalise y, dot products with the eye, rounding and saturation
// each normaliser takes FRAC_BITS + 40 stages (one square-root bit per stage, one
// quotient bit per stage)
// the pipeline itself accepts a beat every cycle while the row serialiser keeps up
// when m_tready is low the row serialiser holds its row; the whole pipeline freezes,
// and s_tready drops, only while a finished matrix waits at the pipeline end
// reset (aresetn low, synchronous) empties the pipeline and the serialiser
module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [287:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // row_index, col_0, col_1, col_2, col_3, zero pad
    output logic [135:0]  m_tdata,
    // degenerate
    output logic          m_tuser,
    output logic          m_tlast
);

    localparam int CW = lav_pkg::COORD_W;
    localparam int RW = lav_pkg::ROW_W;
    localparam int BW = FRAC_BITS + 2;
    localparam int EW = 3 * CW;
    localparam int DIW = CW + 1;
    localparam int XIW = CW + BW + 1;
    localparam int YIW = 2 * BW + 1;
    localparam int S0W = 2 * EW;
    localparam int S1W = EW + 3 * BW + 1;
    localparam int S2W = EW + 6 * BW + 1;
    localparam int PW = CW + BW;
    localparam int DW = PW + 2;
    localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] MAXPOS = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINNEG = {1'b1, {(CW-1){1'b0}}};
    localparam logic [DW-1:0] SAT_POS = DW'(MAXPOS);
    localparam logic [DW-1:0] SAT_NEG = DW'(MINNEG);
    localparam logic [DW-1:0] HALF = DW'(1) << (FRAC_BITS - 1);

    logic en;

    lav_pkg::coord_t eye_in [3], tgt_in [3], up_in [3];

    logic                  p0_valid_reg;
    logic signed [DIW-1:0] p0_d_reg [3];
    logic signed [DIW-1:0] p0_d_next [3];
    logic [S0W-1:0]        p0_side_reg, p0_side_next;

    logic                  nz_valid, nz_zero;
    logic signed [BW-1:0]  nz_u [3];
    logic [S0W-1:0]        nz_side;
    logic signed [CW-1:0]  c1_a [3];
    logic [S1W-1:0]        c1_side_in;

    logic                  c1_valid;
    logic signed [XIW-1:0] c1_o [3];
    logic [S1W-1:0]        c1_side;

    logic                  nx_valid, nx_zero;
    logic signed [BW-1:0]  nx_u [3];
    logic [S1W-1:0]        nx_side;
    logic signed [BW-1:0]  c2_a [3];
    logic [S2W-1:0]        c2_side_in;

    logic                  c2_valid;
    logic signed [YIW-1:0] c2_o [3];
    logic [S2W-1:0]        c2_side;

    logic                  ny_valid, ny_zero;
    logic signed [BW-1:0]  ny_u [3];
    logic [S2W-1:0]        ny_side;

    logic signed [BW-1:0]  basis [3][3];
    lav_pkg::coord_t       eye_b [3];

    logic                  p5_valid_reg, p5_deg_reg;
    logic signed [PW-1:0]  p5_prod_reg [3][3];
    logic signed [PW-1:0]  p5_prod_next [3][3];
    logic signed [BW-1:0]  p5_basis_reg [3][3];

    logic                  p6_valid_reg, p6_deg_reg;
    logic signed [DW-1:0]  p6_dot_reg [3];
    logic signed [DW-1:0]  p6_dot_next [3];
    logic signed [BW-1:0]  p6_basis_reg [3][3];

    logic                  p7_valid_reg, p7_deg_reg;
    logic [CW-1:0]         p7_trans_reg [3];
    logic [CW-1:0]         p7_trans_next [3];
    logic signed [BW-1:0]  p7_basis_reg [3][3];
    logic [DW-1:0]         dmag, drnd;

    logic                  busy_reg, busy_next;
    logic [RW-1:0]         row_reg, row_next;
    logic signed [BW-1:0]  mat_basis_reg [3][3];
    logic [CW-1:0]         mat_trans_reg [3];
    logic                  mat_deg_reg;
    logic                  ser_load;
    logic [CW-1:0]         col [4];

    // input difference
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            eye_in[i] = s_tdata[i*CW +: CW];
            tgt_in[i] = s_tdata[(3+i)*CW +: CW];
            up_in[i]  = s_tdata[(6+i)*CW +: CW];
            p0_d_next[i] = DIW'(eye_in[i]) - DIW'(tgt_in[i]);
        end
        p0_side_next = {up_in[2], up_in[1], up_in[0], eye_in[2], eye_in[1], eye_in[0]};
    end

    lav_norm #(.IW(DIW), .FRAC_BITS(FRAC_BITS), .SIDE_W(S0W)) u_norm_z (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p0_valid_reg),
        .v_in(p0_d_reg), .side_in(p0_side_reg),
        .out_valid(nz_valid), .u_out(nz_u), .zero_out(nz_zero), .side_out(nz_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c1_a[i] = nz_side[EW + i*CW +: CW];
        end
        c1_side_in = {nz_zero, nz_u[2], nz_u[1], nz_u[0], nz_side[EW-1:0]};
    end

    lav_cross #(.A_W(CW), .B_W(BW), .SIDE_W(S1W)) u_cross_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(nz_valid),
        .a_in(c1_a), .b_in(nz_u), .side_in(c1_side_in),
        .out_valid(c1_valid), .c_out(c1_o), .side_out(c1_side)
    );

    lav_norm #(.IW(XIW), .FRAC_BITS(FRAC_BITS), .SIDE_W(S1W)) u_norm_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(c1_valid),
        .v_in(c1_o), .side_in(c1_side),
        .out_valid(nx_valid), .u_out(nx_u), .zero_out(nx_zero), .side_out(nx_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c2_a[i] = nx_side[EW + i*BW +: BW];
        end
        c2_side_in = {nx_side[EW + 3*BW] | nx_zero, nx_u[2], nx_u[1], nx_u[0],
                      nx_side[EW + 3*BW - 1:0]};
    end

    lav_cross #(.A_W(BW), .B_W(BW), .SIDE_W(S2W)) u_cross_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(nx_valid),
        .a_in(c2_a), .b_in(nx_u), .side_in(c2_side_in),
        .out_valid(c2_valid), .c_out(c2_o), .side_out(c2_side)
    );

    lav_norm #(.IW(YIW), .FRAC_BITS(FRAC_BITS), .SIDE_W(S2W)) u_norm_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(c2_valid),
        .v_in(c2_o), .side_in(c2_side),
        .out_valid(ny_valid), .u_out(ny_u), .zero_out(ny_zero), .side_out(ny_side)
    );

    // translation: products, sums, rounding with saturation
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            eye_b[i]    = ny_side[i*CW +: CW];
            basis[0][i] = ny_side[EW + 3*BW + i*BW +: BW];
            basis[1][i] = ny_u[i];
            basis[2][i] = ny_side[EW + i*BW +: BW];
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                p5_prod_next[r][c] = basis[r][c] * eye_b[c];
            end
            p6_dot_next[r] = DW'(p5_prod_reg[r][0]) + DW'(p5_prod_reg[r][1])
                           + DW'(p5_prod_reg[r][2]);
        end
        dmag = '0;
        drnd = '0;
        for (int r = 0; r < 3; r++) begin
            dmag = p6_dot_reg[r][DW-1] ? DW'(-p6_dot_reg[r]) : DW'(p6_dot_reg[r]);
            drnd = (dmag + HALF) >> FRAC_BITS;
            if (p6_dot_reg[r][DW-1]) begin
                p7_trans_next[r] = (drnd > SAT_POS) ? MAXPOS : drnd[CW-1:0];
            end else begin
                p7_trans_next[r] = (drnd > SAT_NEG) ? MINNEG : CW'(-drnd[CW-1:0]);
            end
        end
    end

    // row serialiser
    assign ser_load = p7_valid_reg && (!busy_reg || (m_tready && row_reg == lav_pkg::ROW_LAST));
    assign en       = !p7_valid_reg || ser_load;
    assign s_tready = en;

    always_comb begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (ser_load) begin
            busy_next = 1'b1;
            row_next  = '0;
        end else if (busy_reg && m_tready) begin
            if (row_reg == lav_pkg::ROW_LAST) begin
                busy_next = 1'b0;
            end
            row_next = row_reg + RW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
            p7_valid_reg <= 1'b0;
            busy_reg     <= 1'b0;
            row_reg      <= '0;
        end else begin
            if (en) begin
                p0_valid_reg <= s_tvalid;
                p5_valid_reg <= ny_valid;
                p6_valid_reg <= p5_valid_reg;
                p7_valid_reg <= p6_valid_reg;
            end
            busy_reg <= busy_next;
            row_reg  <= row_next;
        end
        if (en) begin
            p0_d_reg      <= p0_d_next;
            p0_side_reg   <= p0_side_next;
            p5_prod_reg   <= p5_prod_next;
            p5_basis_reg  <= basis;
            p5_deg_reg    <= ny_side[EW + 6*BW] | ny_zero;
            p6_dot_reg    <= p6_dot_next;
            p6_basis_reg  <= p5_basis_reg;
            p6_deg_reg    <= p5_deg_reg;
            p7_trans_reg  <= p7_trans_next;
            p7_basis_reg  <= p6_basis_reg;
            p7_deg_reg    <= p6_deg_reg;
        end
        if (ser_load) begin
            mat_basis_reg <= p7_basis_reg;
            mat_trans_reg <= p7_trans_reg;
            mat_deg_reg   <= p7_deg_reg;
        end
    end

    always_comb begin
        col[0] = '0;
        col[1] = '0;
        col[2] = '0;
        col[3] = ONE;
        if (row_reg != lav_pkg::ROW_LAST) begin
            for (int i = 0; i < 3; i++) begin
                col[i] = CW'(mat_basis_reg[row_reg][i]);
            end
            col[3] = mat_trans_reg[row_reg];
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {6'b0, col[3], col[2], col[1], col[0], row_reg};
    assign m_tuser  = mat_deg_reg;
    assign m_tlast  = (row_reg == lav_pkg::ROW_LAST);

    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && row_reg == $past(row_reg) + RW'(1)))
        else $error("row sequence broken");

    a_load_row0: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_load |=> (m_tvalid && row_reg == '0))
        else $error("matrix load does not start at row 0");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (p7_valid_reg && busy_reg))
        else $error("input stalled without a waiting matrix");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast && !p7_valid_reg) |=> !m_tvalid)
        else $error("rows emitted without a matrix");

endmodule

### rtl/core/lav_cross.sv
module lav_cross #(
    parameter int A_W = 32,
    parameter int B_W = 18,
    parameter int SIDE_W = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [A_W-1:0]     a_in [3],
    input  logic signed [B_W-1:0]     b_in [3],
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      out_valid,
    output logic signed [A_W+B_W:0]   c_out [3],
    output logic [SIDE_W-1:0]         side_out
);

    localparam int PW = A_W + B_W;
    localparam int OW = PW + 1;

    logic [1:0]            vld_reg;
    logic signed [PW-1:0]  prod_reg [6];
    logic signed [PW-1:0]  prod_next [6];
    logic signed [OW-1:0]  c_reg [3];
    logic signed [OW-1:0]  c_next [3];
    logic [SIDE_W-1:0]     side1_reg;
    logic [SIDE_W-1:0]     side2_reg;

    always_comb begin
        prod_next[0] = a_in[1] * b_in[2];
        prod_next[1] = a_in[2] * b_in[1];
        prod_next[2] = a_in[2] * b_in[0];
        prod_next[3] = a_in[0] * b_in[2];
        prod_next[4] = a_in[0] * b_in[1];
        prod_next[5] = a_in[1] * b_in[0];
        for (int i = 0; i < 3; i++) begin
            c_next[i] = OW'(prod_reg[2*i]) - OW'(prod_reg[2*i+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[0], in_valid};
        end
        if (en) begin
            prod_reg  <= prod_next;
            c_reg     <= c_next;
            side1_reg <= side_in;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = vld_reg[1];
    assign c_out     = c_reg;
    assign side_out  = side2_reg;

endmodule

### rtl/core/lav_norm.sv
module lav_norm #(
    parameter int IW = 33,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [IW-1:0]          v_in [3],
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic signed [FRAC_BITS+1:0]   u_out [3],
    output logic                          zero_out,
    output logic [SIDE_W-1:0]             side_out
);

    localparam int MB = lav_pkg::MAG_BITS;
    localparam int LW = lav_pkg::COORD_W;
    localparam int SQ = 2 * LW;
    localparam int SHW = $clog2(IW + 1);
    localparam int NW = LW + FRAC_BITS;
    localparam int QW = FRAC_BITS + 1;
    localparam int UW = FRAC_BITS + 2;
    localparam int NSQ = LW;
    localparam int CW = 3 * MB + 4 + SIDE_W;
    localparam int NST = NSQ + QW + 7;

    logic [NST-1:0]      vld_reg;

    // abs and sign
    logic [IW-1:0]       s1_mag_reg [3];
    logic [IW-1:0]       s1_mag_next [3];
    logic [2:0]          s1_neg_reg, s1_neg_next;
    logic [SIDE_W-1:0]   s1_side_reg;

    // common shift
    logic [IW-1:0]       s2_mag_reg [3];
    logic [2:0]          s2_neg_reg;
    logic [SHW-1:0]      s2_shamt_reg, s2_shamt_next;
    logic [SIDE_W-1:0]   s2_side_reg;
    logic [IW-1:0]       or_all;

    logic [MB-1:0]       s3_m_reg [3];
    logic [MB-1:0]       s3_m_next [3];
    logic [2:0]          s3_neg_reg;
    logic [SIDE_W-1:0]   s3_side_reg;

    logic [2*MB-1:0]     s4_sq_reg [3];
    logic [2*MB-1:0]     s4_sq_next [3];
    logic [MB-1:0]       s4_m_reg [3];
    logic [2:0]          s4_neg_reg;
    logic [SIDE_W-1:0]   s4_side_reg;

    // square root, one result bit per stage
    logic [SQ-1:0]       sq_n_reg [NSQ+1];
    logic [SQ-1:0]       sq_n_next [NSQ+1];
    logic [SQ-1:0]       sq_res_reg [NSQ+1];
    logic [SQ-1:0]       sq_res_next [NSQ+1];
    logic [CW-1:0]       sq_c_reg [NSQ+1];
    logic [CW-1:0]       sq_c_next [NSQ+1];
    logic [SQ-1:0]       trial;

    // restoring division, one quotient bit per stage
    logic [NW-1:0]       dv_r_reg [QW+1][3];
    logic [NW-1:0]       dv_r_next [QW+1][3];
    logic [QW-1:0]       dv_q_reg [QW+1][3];
    logic [QW-1:0]       dv_q_next [QW+1][3];
    logic [LW-1:0]       dv_len_reg [QW+1];
    logic [LW-1:0]       dv_len_next [QW+1];
    logic [CW-1:0]       dv_c_reg [QW+1];
    logic [CW-1:0]       dv_c_next [QW+1];
    logic [NW-1:0]       dsub;
    logic [LW-1:0]       len;
    logic [MB-1:0]       mq;

    logic signed [UW-1:0] u_reg [3];
    logic signed [UW-1:0] u_next [3];
    logic                 zero_reg;
    logic [SIDE_W-1:0]    side_reg;
    logic [CW-1:0]        cfin;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s1_neg_next[i] = v_in[i][IW-1];
            s1_mag_next[i] = s1_neg_next[i] ? IW'(-v_in[i]) : IW'(v_in[i]);
        end

        or_all = s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2];
        s2_shamt_next = '0;
        for (int p = MB; p < IW; p++) begin
            if (or_all[p]) begin
                s2_shamt_next = SHW'(p - MB + 1);
            end
        end

        for (int i = 0; i < 3; i++) begin
            s3_m_next[i]  = MB'(s2_mag_reg[i] >> s2_shamt_reg);
            s4_sq_next[i] = s3_m_reg[i] * s3_m_reg[i];
        end

        sq_n_next[0] = SQ'(s4_sq_reg[0]) + SQ'(s4_sq_reg[1]) + SQ'(s4_sq_reg[2]);
        sq_res_next[0] = '0;
        sq_c_next[0] = {s4_side_reg,
                        ((s4_m_reg[0] | s4_m_reg[1] | s4_m_reg[2]) == '0),
                        s4_neg_reg, s4_m_reg[2], s4_m_reg[1], s4_m_reg[0]};
        for (int k = 0; k < NSQ; k++) begin
            trial = sq_res_reg[k] + (SQ'(1) << (SQ - 2 - 2 * k));
            if (sq_n_reg[k] >= trial) begin
                sq_n_next[k+1]   = sq_n_reg[k] - trial;
                sq_res_next[k+1] = (sq_res_reg[k] >> 1) + (SQ'(1) << (SQ - 2 - 2 * k));
            end else begin
                sq_n_next[k+1]   = sq_n_reg[k];
                sq_res_next[k+1] = sq_res_reg[k] >> 1;
            end
            sq_c_next[k+1] = sq_c_reg[k];
        end

        len = sq_res_reg[NSQ][LW-1:0];
        dv_len_next[0] = len;
        dv_c_next[0] = sq_c_reg[NSQ];
        for (int i = 0; i < 3; i++) begin
            mq = sq_c_reg[NSQ][i*MB +: MB];
            dv_r_next[0][i] = (NW'(mq) << FRAC_BITS) + NW'(len >> 1);
            dv_q_next[0][i] = '0;
        end
        for (int j = 0; j < QW; j++) begin
            dv_len_next[j+1] = dv_len_reg[j];
            dv_c_next[j+1]   = dv_c_reg[j];
            dsub = NW'(dv_len_reg[j]) << (QW - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (dv_r_reg[j][i] >= dsub) begin
                    dv_r_next[j+1][i] = dv_r_reg[j][i] - dsub;
                    dv_q_next[j+1][i] = dv_q_reg[j][i] | (QW'(1) << (QW - 1 - j));
                end else begin
                    dv_r_next[j+1][i] = dv_r_reg[j][i];
                    dv_q_next[j+1][i] = dv_q_reg[j][i];
                end
            end
        end

        cfin = dv_c_reg[QW];
        for (int i = 0; i < 3; i++) begin
            if (cfin[3*MB+3]) begin
                u_next[i] = '0;
            end else if (cfin[3*MB+i]) begin
                u_next[i] = -UW'(dv_q_reg[QW][i]);
            end else begin
                u_next[i] = UW'(dv_q_reg[QW][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
        if (en) begin
            s1_mag_reg   <= s1_mag_next;
            s1_neg_reg   <= s1_neg_next;
            s1_side_reg  <= side_in;
            s2_mag_reg   <= s1_mag_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_shamt_reg <= s2_shamt_next;
            s2_side_reg  <= s1_side_reg;
            s3_m_reg     <= s3_m_next;
            s3_neg_reg   <= s2_neg_reg;
            s3_side_reg  <= s2_side_reg;
            s4_sq_reg    <= s4_sq_next;
            s4_m_reg     <= s3_m_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_side_reg  <= s3_side_reg;
            sq_n_reg     <= sq_n_next;
            sq_res_reg   <= sq_res_next;
            sq_c_reg     <= sq_c_next;
            dv_r_reg     <= dv_r_next;
            dv_q_reg     <= dv_q_next;
            dv_len_reg   <= dv_len_next;
            dv_c_reg     <= dv_c_next;
            u_reg        <= u_next;
            zero_reg     <= cfin[3*MB+3];
            side_reg     <= cfin[3*MB+4 +: SIDE_W];
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign u_out     = u_reg;
    assign zero_out  = zero_reg;
    assign side_out  = side_reg;

endmodule

### bench/look_at_view_matrix_checker.sv
`timescale 1ns / 1ps

module look_at_view_matrix_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic         m_tuser,
    input  logic         m_tlast,
    output int           fail_count,
    output int           rows_pending
);

    localparam int FRAC = 16;

    typedef struct packed {
        logic [1:0]       row_index;
        lav_pkg::coord_t  col_0;
        lav_pkg::coord_t  col_1;
        lav_pkg::coord_t  col_2;
        lav_pkg::coord_t  col_3;
        logic             degenerate;
        logic             last_row;
    } matrix_row_t;

    matrix_row_t expected_rows[$];

    assign rows_pending = expected_rows.size();

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // returns 0 for a zero-length vector
    function automatic logic normalise(input longint v[3], output longint o[3]);
        logic [63:0] m[3];
        logic        neg[3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            m[i] = neg[i] ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
        if (sum == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return 1'b0;
        end
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC) + len / 2) / len;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic lav_pkg::coord_t eye_offset(input longint b[3], input longint e[3]);
        longint      dot;
        logic [63:0] mag;
        longint      r;
        longint      t;
        dot = b[0] * e[0] + b[1] * e[1] + b[2] * e[2];
        mag = dot < 0 ? -dot : dot;
        r = longint'((mag + (64'd1 << (FRAC - 1))) >> FRAC);
        t = dot < 0 ? r : -r;
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return lav_pkg::coord_t'(t);
    endfunction

    task automatic predict_matrix(input logic [287:0] d);
        longint      eye[3];
        longint      diff[3];
        longint      tmp[3];
        longint      up[3];
        longint      basis[3][3];
        logic        deg;
        matrix_row_t r;
        deg = 1'b0;
        for (int i = 0; i < 3; i++) begin
            eye[i] = lav_pkg::coord_t'(d[32*i +: 32]);
            up[i] = lav_pkg::coord_t'(d[32*(6+i) +: 32]);
            diff[i] = eye[i] - longint'(lav_pkg::coord_t'(d[32*(3+i) +: 32]));
        end
        if (!normalise(diff, basis[2])) deg = 1'b1;
        cross3(up, basis[2], tmp);
        if (!normalise(tmp, basis[0])) deg = 1'b1;
        cross3(basis[2], basis[0], tmp);
        if (!normalise(tmp, basis[1])) deg = 1'b1;
        for (int k = 0; k < 4; k++) begin
            r.row_index = k[1:0];
            r.degenerate = deg;
            r.last_row = (k == 3);
            if (k < 3) begin
                r.col_0 = lav_pkg::coord_t'(basis[k][0]);
                r.col_1 = lav_pkg::coord_t'(basis[k][1]);
                r.col_2 = lav_pkg::coord_t'(basis[k][2]);
                r.col_3 = eye_offset(basis[k], eye);
            end else begin
                r.col_0 = 0;
                r.col_1 = 0;
                r.col_2 = 0;
                r.col_3 = 32'sd1 << FRAC;
            end
            expected_rows.push_back(r);
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        matrix_row_t w;
        if (!aresetn) begin
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready) predict_matrix(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    report("unexpected row", m_tdata[63:0], 0);
                end else begin
                    w = expected_rows.pop_front();
                    if (m_tdata[1:0] != w.row_index) report("row_index", m_tdata[1:0], w.row_index);
                    if (m_tdata[33:2] != w.col_0) report("col_0", m_tdata[33:2], w.col_0);
                    if (m_tdata[65:34] != w.col_1) report("col_1", m_tdata[65:34], w.col_1);
                    if (m_tdata[97:66] != w.col_2) report("col_2", m_tdata[97:66], w.col_2);
                    if (m_tdata[129:98] != w.col_3) report("col_3", m_tdata[129:98], w.col_3);
                    if (m_tuser != w.degenerate) report("degenerate", m_tuser, w.degenerate);
                    if (m_tlast != w.last_row) report("last_row", m_tlast, w.last_row);
                end
            end
        end
    end
endmodule

### bench/look_at_view_matrix_tb.sv
`timescale 1ns / 1ps

module look_at_view_matrix_tb;

    localparam int LATENCY = 3 * 16 + 129 + 8;
    localparam int CYCLE_LIMIT = 400000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    int           fail_count;
    int           rows_pending;
    int           cycle_count;
    logic         long_hold;
    logic         hold_request;

    look_at_view_matrix i_dut (.*);

    look_at_view_matrix_checker i_checker (.*);

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic lav_pkg::coord_t rand_coord(input int mode);
        case (mode)
            0: return lav_pkg::coord_t'($urandom);
            1: return lav_pkg::coord_t'($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
            2: return lav_pkg::coord_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    task automatic send_view(input lav_pkg::coord_t c[9]);
        @(posedge aclk);
        s_tvalid <= 1'b1;
        for (int i = 0; i < 9; i++) s_tdata[32*i +: 32] <= c[i];
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
    endtask

    // send without dropping valid between beats of a burst
    task automatic send_burst(input int count, input int mode);
        lav_pkg::coord_t c[9];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 9; i++) c[i] = rand_coord($urandom_range(0, 9) == 0 ? 0 : mode);
            if ($urandom_range(0, 15) == 0) for (int i = 3; i < 6; i++) c[i] = c[i-3];
            if ($urandom_range(0, 15) == 0) for (int i = 6; i < 9; i++) c[i] = c[i-6] - c[i-3];
            if ($urandom_range(0, 20) == 0) for (int i = 6; i < 9; i++) c[i] = 0;
            s_tvalid <= 1'b1;
            for (int i = 0; i < 9; i++) s_tdata[32*i +: 32] <= c[i];
            do @(posedge aclk); while (!s_tready);
        end
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall pattern, plus one long hold on request
    initial begin
        int hold;
        long_hold = 1'b0;
        wait (hold_request);
        long_hold = 1'b1;
        hold = 0;
        while (hold < 600) begin
            @(posedge aclk);
            hold++;
        end
        long_hold = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || long_hold) begin
            m_tready <= 1'b0;
        end else if (cycle_count[9:8] == 2'd1) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        lav_pkg::coord_t c[9];
        lav_pkg::coord_t dir[9];
        int     sent;
        hold_request = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // ordinary camera: eye (0,0,5), target origin, up y
        dir = '{0, 0, 32'sh0005_0000, 0, 0, 0, 0, 32'sh0001_0000, 0};
        send_view(dir);
        // eye equals target
        dir = '{32'sh0001_0000, 2, 3, 32'sh0001_0000, 2, 3, 0, 32'sh0001_0000, 0};
        send_view(dir);
        // up parallel to the view direction
        dir = '{0, 32'sh0003_0000, 0, 0, 0, 0, 0, 32'sh0001_0000, 0};
        send_view(dir);
        // zero up vector
        dir = '{1, 2, 3, 4, 5, 6, 0, 0, 0};
        send_view(dir);
        // extremes, saturating translation
        for (int k = 0; k < 9; k++) c[k] = 32'sh7FFF_FFFF;
        c[3] = 32'sh8000_0000; c[4] = 32'sh8000_0000; c[6] = 32'sh8000_0000;
        send_view(c);
        for (int k = 0; k < 9; k++) c[k] = 32'sh8000_0000;
        c[3] = 32'sh7FFF_FFFF; c[7] = 32'sh7FFF_FFFF;
        send_view(c);
        dir = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 0, 32'sh8000_0000};
        send_view(dir);
        dir = '{-1, -1, -1, 0, 0, 0, 1, 0, 0};
        send_view(dir);
        for (int k = 0; k < 12; k++) begin
            for (int i = 0; i < 9; i++) c[i] = rand_coord(k % 4);
            send_view(c);
        end

        // pause until every row is back
        while (rows_pending != 0) @(posedge aclk);

        // long receiver hold while items keep coming, more than the pipeline holds
        hold_request = 1'b1;
        send_burst(200, 1);
        sent = 220;

        while (sent < 460) begin
            int n;
            n = $urandom_range(1, 12);
            send_burst(n, $urandom_range(0, 3));
            sent += n;
            if ($urandom_range(0, 2) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        while (rows_pending != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
        if (fail_count == 0 && rows_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
